FILE: hdl/trial_division_prime_test_macros.svh
// Assertion macros for the trial-division primality tester.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef TRIAL_DIVISION_PRIME_TEST_MACROS_SVH
`define TRIAL_DIVISION_PRIME_TEST_MACROS_SVH

// Same-cycle implication, checked outside reset
`define TDPT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define TDPT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/tdpt_pkg.sv
// Package for the trial-division primality tester: default width,
// first divisor, divisor step and the sequencer state type. No dependencies.
package tdpt_pkg;

	localparam int VALUE_WIDTH_DEF = 31;
	localparam int FIRST_DIVISOR   = 3;
	localparam int DIVISOR_STEP    = 2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIVIDE,
		ST_HOLD
	} tdpt_state_t;

endpackage

FILE: hdl/trial_division_prime_test.sv
// Candidates 0, 1, 2 and even ones are settled at once and go straight to ST_HOLD.
// Odd candidates above one alternate ST_CHECK and ST_DIVIDE, one full division per divisor,
// until a divisor divides (not prime) or the divisor squared exceeds the candidate (prime).
// Throughput: one candidate at a time; the next is taken once the last reaches the result
// register. A result waiting downstream blocks entry, since ST_HOLD waits for it to be taken.
// Reset (arst_n, asynchronous, active low) returns to idle with no result pending.
`include "trial_division_prime_test_macros.svh"

module trial_division_prime_test
	import tdpt_pkg::*;
#(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [VALUE_WIDTH-1:0] candidate,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   is_prime
);

	localparam int BIT_W = $clog2(VALUE_WIDTH);
	localparam int SQ_W  = VALUE_WIDTH + 2;

	localparam logic [VALUE_WIDTH-1:0] DIV_FIRST = VALUE_WIDTH'(FIRST_DIVISOR);
	localparam logic [VALUE_WIDTH-1:0] DIV_STEP  = VALUE_WIDTH'(DIVISOR_STEP);
	localparam logic [SQ_W-1:0]        SQ_FIRST  = SQ_W'(FIRST_DIVISOR * FIRST_DIVISOR);
	localparam logic [BIT_W-1:0]       BIT_TOP   = BIT_W'(VALUE_WIDTH - 1);

	tdpt_state_t state_q, state_d;

	logic [VALUE_WIDTH-1:0] held_q;
	logic [VALUE_WIDTH-1:0] divisor_q;
	logic [SQ_W-1:0]        sq_q;
	logic [VALUE_WIDTH-1:0] rem_q;
	logic [BIT_W-1:0]       bit_q;
	logic                   result_q;
	logic                   out_valid_q;
	logic                   is_prime_q;

	logic                   in_beat;
	logic                   out_free;
	logic                   quick_done;
	logic                   quick_result;
	logic                   bound_hit;
	logic [VALUE_WIDTH:0]   trial;
	logic [VALUE_WIDTH+1:0] diff;
	logic                   trial_ge;
	logic [VALUE_WIDTH-1:0] rem_next;
	logic                   last_bit;
	logic                   load_s;
	logic                   check_prime;

	// Handshake terms
	assign in_beat  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Settle small and even candidates without dividing
	always_comb begin
		quick_done   = 1'b1;
		quick_result = 1'b0;
		if (candidate == VALUE_WIDTH'(DIVISOR_STEP)) begin
			quick_result = 1'b1;
		end else if (candidate[0] && candidate > VALUE_WIDTH'(1)) begin
			quick_done = 1'b0;
		end
	end

	// Stop once the divisor squared exceeds the candidate
	assign bound_hit = sq_q > SQ_W'(held_q);

	// Shared restoring divider: one remainder bit per cycle
	assign trial    = {rem_q, held_q[bit_q]};
	assign diff     = {1'b0, trial} - {2'b00, divisor_q};
	assign trial_ge = !diff[VALUE_WIDTH+1];
	assign rem_next = trial_ge ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
	assign last_bit = bit_q == '0;

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and stall
	always_comb begin
		state_d     = state_q;
		in_stall    = 1'b1;
		load_s      = 1'b0;
		check_prime = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = quick_done ? ST_HOLD : ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (bound_hit) begin
					check_prime = 1'b1;
					state_d     = ST_HOLD;
				end else begin
					state_d = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (last_bit) begin
					state_d = (rem_next == '0) ? ST_HOLD : ST_CHECK;
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					load_s  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Datapath: candidate, divisor, square, remainder, bit counter, pending result
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_beat) begin
					held_q    <= candidate;
					divisor_q <= DIV_FIRST;
					sq_q      <= SQ_FIRST;
					result_q  <= quick_result;
				end
			end
			ST_CHECK: begin
				rem_q <= '0;
				bit_q <= BIT_TOP;
				if (check_prime) begin
					result_q <= 1'b1;
				end
			end
			ST_DIVIDE: begin
				rem_q <= rem_next;
				bit_q <= bit_q - BIT_W'(1);
				if (last_bit) begin
					if (rem_next == '0) begin
						result_q <= 1'b0;
					end else begin
						// Advance to the next odd divisor: (d+2)^2 = d^2 + 4d + 4
						divisor_q <= divisor_q + DIV_STEP;
						sq_q      <= sq_q + {divisor_q, 2'b00} + SQ_W'(4);
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Result register: hold until taken downstream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_s) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s) begin
			is_prime_q <= result_q;
		end
	end

	assign out_valid = out_valid_q;
	assign is_prime  = is_prime_q;

	// Checks on the sequencer and divider
	`TDPT_ASSERT_NOW(a_div_odd, state_q == ST_DIVIDE,
		divisor_q[0] && divisor_q >= DIV_FIRST, "divisor not odd or below three")
	`TDPT_ASSERT_NOW(a_rem_below, state_q == ST_DIVIDE, rem_q < divisor_q,
		"remainder not below divisor")
	`TDPT_ASSERT_NOW(a_sq_track, state_q == ST_CHECK,
		(2*VALUE_WIDTH)'(sq_q) == (2*VALUE_WIDTH)'(divisor_q) * (2*VALUE_WIDTH)'(divisor_q),
		"square out of step with divisor")
	`TDPT_ASSERT_NEXT(a_out_from_hold, !out_valid_q && state_q != ST_HOLD, !out_valid_q,
		"result shown without a finished item")

endmodule
